[rtl/core/line_follow_pd_steering_core_assert.svh]
// Assertion macros for the line-follow PD steering core.
`ifndef LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH
`ifndef SYNTH
`define LFPD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfpd assertion failed");
`define LFPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfpd assertion failed");
`else
`define LFPD_ASSERT_IMPLY(label, ante, cons)
`define LFPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/lfpd_pkg.sv]
// Types, codes and constants shared by the line-follow PD steering core.
`default_nettype none
package lfpd_pkg;

  typedef logic [1:0]        op_t;
  typedef logic signed [6:0] err_t;
  typedef logic [3:0]        sensors_t;
  typedef logic [31:0]       dist_t;
  typedef logic [1:0]        status_t;
  typedef logic [7:0]        brake_t;
  typedef logic [1:0]        kind_t;
  typedef logic [11:0]       speed_t;
  typedef logic [2:0]        cfg_idx_t;
  typedef logic [31:0]       cfg_data_t;
  typedef logic signed [24:0] prod_t;
  typedef logic signed [25:0] q_t;

  // Input operations.
  localparam op_t OP_TICK   = 2'd0;
  localparam op_t OP_STATUS = 2'd1;
  localparam op_t OP_BRAKE  = 2'd2;

  // Result kinds.
  localparam kind_t KIND_SPEED = 2'd0;
  localparam kind_t KIND_BRAKE = 2'd1;
  localparam kind_t KIND_HOLD  = 2'd2;
  localparam kind_t KIND_NONE  = 2'd3;

  // Run status codes.
  localparam status_t RUN_STOPPED = 2'd0;
  localparam status_t RUN_DETECT  = 2'd1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_GAIN_P    = 3'd0;
  localparam cfg_idx_t CFG_GAIN_D    = 3'd1;
  localparam cfg_idx_t CFG_BASE      = 3'd2;
  localparam cfg_idx_t CFG_NONSTOP   = 3'd3;
  localparam cfg_idx_t CFG_STOP_DIST = 3'd4;

  localparam logic [15:0] GAIN_P_RESET    = 16'd8960;
  localparam logic [15:0] GAIN_D_RESET    = 16'd3840;
  localparam speed_t      BASE_RESET      = 12'd300;
  localparam dist_t       STOP_DIST_RESET = 32'd10000;

  localparam logic [15:0] SOFT_KP   = 16'd3840;
  localparam logic [15:0] SOFT_KD   = 16'd1536;
  localparam speed_t      SOFT_BASE = 12'd200;

  localparam sensors_t CROWDED_SENSORS = 4'd5;
  localparam speed_t   MIN_SPEED       = 12'd30;
  localparam speed_t   MAX_SPEED       = 12'd4095;
  localparam q_t       MIN_SPEED_Q     = 26'sd7680;
  localparam q_t       ROUND_HALF      = 26'sd128;

  // Signed Q18.8 target to wheel speed: floor at the minimum, round half up, saturate.
  function automatic speed_t to_speed(input q_t q);
    q_t          rounded;
    logic [17:0] whole;
    begin
      rounded = q + ROUND_HALF;
      whole   = rounded[25:8];
      if (q < MIN_SPEED_Q) begin
        to_speed = MIN_SPEED;
      end else if (whole > 18'(MAX_SPEED)) begin
        to_speed = MAX_SPEED;
      end else begin
        to_speed = whole[11:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/lfpd_channels.sv]
// Handshake channel interfaces of the line-follow PD steering core.
`default_nettype none
interface lfpd_in_if;
  logic               valid;
  logic               ready;
  lfpd_pkg::op_t      op;
  lfpd_pkg::err_t     line_error;
  lfpd_pkg::sensors_t active_sensors;
  logic               stop_sensor;
  lfpd_pkg::dist_t    distance;
  lfpd_pkg::status_t  status_value;
  lfpd_pkg::brake_t   brake_ticks;

  modport source (output valid, op, line_error, active_sensors, stop_sensor, distance,
                  status_value, brake_ticks, input ready);
  modport sink (input valid, op, line_error, active_sensors, stop_sensor, distance,
                status_value, brake_ticks, output ready);
endinterface

interface lfpd_out_if;
  logic             valid;
  logic             ready;
  lfpd_pkg::kind_t  drive_kind;
  lfpd_pkg::speed_t left_target;
  lfpd_pkg::speed_t right_target;
  logic             pid_reset;
  logic             stop_line_hit;

  modport source (output valid, drive_kind, left_target, right_target, pid_reset,
                  stop_line_hit, input ready);
  modport sink (input valid, drive_kind, left_target, right_target, pid_reset,
                stop_line_hit, output ready);
endinterface

interface lfpd_cfg_if;
  logic                valid;
  logic                ready;
  lfpd_pkg::cfg_idx_t  index;
  lfpd_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/line_follow_pd_steering_core.sv]
// Line-follow PD steering core: state update, gain products and wheel target shaping.
//
//   channel  direction  transfer when        payload
//   in_ch    sink       valid && ready       op, sensor error, sensors, stop bit, distance
//   out_ch   source     valid && ready       drive kind, left/right targets, flags
//   cfg_ch   sink       valid (ready tied)   register index, write data
//
// One item per cycle sustained while the output is not stalled; each result passes both registers.
// The first register holds the two gain products, the second the shaped targets.
// Run state, brake count and error history update at the input transfer itself.
// A stalled output holds both registers; input is refused only when both are full.
// rst_n is synchronous: configuration returns to its defaults and status to stopped.
`default_nettype none
module line_follow_pd_steering_core (
  input  wire           clk,
  input  wire           rst_n,
  lfpd_in_if.sink       in_ch,
  lfpd_out_if.source    out_ch,
  lfpd_cfg_if.sink      cfg_ch
);

  `include "line_follow_pd_steering_core_assert.svh"

  // Configuration.
  logic [15:0]       gain_p_r, gain_d_r;
  lfpd_pkg::speed_t  base_r;
  logic              nonstop_r;
  lfpd_pkg::dist_t   stop_dist_r;

  // Run state.
  lfpd_pkg::status_t run_status_r, run_status_nxt;
  lfpd_pkg::brake_t  brake_count_r, brake_count_nxt;
  lfpd_pkg::err_t    prev_err_r, prev_err_nxt;
  lfpd_pkg::err_t    held_err_r, held_err_nxt;
  logic              first_tick_r, first_tick_nxt;

  // Product stage.
  logic              s1_valid_r, s1_valid_nxt;
  lfpd_pkg::kind_t   s1_kind_r, s1_kind_nxt;
  logic              s1_pid_reset_r, s1_pid_reset_nxt;
  logic              s1_hit_r, s1_hit_nxt;
  lfpd_pkg::prod_t   s1_p_r, s1_p_nxt;
  lfpd_pkg::prod_t   s1_d_r, s1_d_nxt;
  lfpd_pkg::speed_t  s1_base_r;

  // Result stage.
  logic              out_valid_r, out_valid_nxt;
  lfpd_pkg::kind_t   out_kind_r;
  lfpd_pkg::speed_t  out_left_r, out_left_nxt;
  lfpd_pkg::speed_t  out_right_r, out_right_nxt;
  logic              out_pid_reset_r;
  logic              out_hit_r;

  logic              in_fire;
  logic              out_free;
  logic              lost_line;
  logic              crowded;
  logic              stop_hit;
  logic              p_only;
  lfpd_pkg::err_t    err_eff;
  logic signed [7:0] err_neg;
  logic signed [7:0] err_diff;
  logic [15:0]       kp, kd;
  lfpd_pkg::speed_t  base_sel;
  lfpd_pkg::q_t      turn;
  lfpd_pkg::q_t      base_q;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign lost_line = (in_ch.active_sensors == '0);
  assign crowded   = (in_ch.active_sensors >= lfpd_pkg::CROWDED_SENSORS);
  assign err_eff   = (lost_line || crowded) ? held_err_r : in_ch.line_error;
  assign err_neg   = -{err_eff[6], err_eff};
  assign err_diff  = {prev_err_r[6], prev_err_r} - {err_eff[6], err_eff};
  // The derivative term is dropped on the tick after a stop and on a lost line.
  assign p_only    = first_tick_r || lost_line;
  assign stop_hit  = !nonstop_r && (run_status_r == lfpd_pkg::RUN_DETECT) &&
                     in_ch.stop_sensor && (in_ch.distance > stop_dist_r);

  assign kp       = nonstop_r ? lfpd_pkg::SOFT_KP : gain_p_r;
  assign kd       = nonstop_r ? lfpd_pkg::SOFT_KD : gain_d_r;
  assign base_sel = nonstop_r ? lfpd_pkg::SOFT_BASE : base_r;

  always_comb begin
    run_status_nxt   = run_status_r;
    brake_count_nxt  = brake_count_r;
    prev_err_nxt     = prev_err_r;
    held_err_nxt     = held_err_r;
    first_tick_nxt   = first_tick_r;
    s1_kind_nxt      = lfpd_pkg::KIND_NONE;
    s1_pid_reset_nxt = 1'b0;
    s1_hit_nxt       = 1'b0;
    s1_p_nxt         = $signed({1'b0, kp}) * err_neg;
    s1_d_nxt         = p_only ? lfpd_pkg::prod_t'(0) : $signed({1'b0, kd}) * err_diff;
    case (in_ch.op)
      lfpd_pkg::OP_TICK: begin
        if (run_status_r == lfpd_pkg::RUN_STOPPED) begin
          s1_pid_reset_nxt = 1'b1;
          if (brake_count_r != '0) begin
            brake_count_nxt = brake_count_r - 8'd1;
            s1_kind_nxt     = lfpd_pkg::KIND_BRAKE;
          end else begin
            s1_kind_nxt     = lfpd_pkg::KIND_HOLD;
          end
          first_tick_nxt = 1'b1;
          held_err_nxt   = '0;
        end else begin
          if (stop_hit) begin
            run_status_nxt  = lfpd_pkg::RUN_STOPPED;
            brake_count_nxt = '0;
            s1_hit_nxt      = 1'b1;
          end
          s1_kind_nxt    = lfpd_pkg::KIND_SPEED;
          held_err_nxt   = err_eff;
          prev_err_nxt   = err_eff;
          first_tick_nxt = 1'b0;
        end
      end
      lfpd_pkg::OP_STATUS: run_status_nxt  = in_ch.status_value;
      lfpd_pkg::OP_BRAKE:  brake_count_nxt = in_ch.brake_ticks;
      default: ;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  // Second stage: sum the products and shape both wheel targets.
  assign turn   = {s1_p_r[24], s1_p_r} + {s1_d_r[24], s1_d_r};
  assign base_q = $signed({6'b0, s1_base_r, 8'b0});

  always_comb begin
    out_left_nxt  = '0;
    out_right_nxt = '0;
    if (s1_kind_r == lfpd_pkg::KIND_SPEED) begin
      out_left_nxt  = lfpd_pkg::to_speed(base_q - turn);
      out_right_nxt = lfpd_pkg::to_speed(base_q + turn);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= lfpd_pkg::GAIN_P_RESET;
      gain_d_r      <= lfpd_pkg::GAIN_D_RESET;
      base_r        <= lfpd_pkg::BASE_RESET;
      nonstop_r     <= 1'b0;
      stop_dist_r   <= lfpd_pkg::STOP_DIST_RESET;
      run_status_r  <= lfpd_pkg::RUN_STOPPED;
      brake_count_r <= '0;
      prev_err_r    <= '0;
      held_err_r    <= '0;
      first_tick_r  <= 1'b1;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          lfpd_pkg::CFG_GAIN_P:    gain_p_r    <= cfg_ch.data[15:0];
          lfpd_pkg::CFG_GAIN_D:    gain_d_r    <= cfg_ch.data[15:0];
          lfpd_pkg::CFG_BASE:      base_r      <= cfg_ch.data[11:0];
          lfpd_pkg::CFG_NONSTOP:   nonstop_r   <= cfg_ch.data[0];
          lfpd_pkg::CFG_STOP_DIST: stop_dist_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_fire) begin
        run_status_r  <= run_status_nxt;
        brake_count_r <= brake_count_nxt;
        prev_err_r    <= prev_err_nxt;
        held_err_r    <= held_err_nxt;
        first_tick_r  <= first_tick_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r      <= s1_kind_nxt;
      s1_pid_reset_r <= s1_pid_reset_nxt;
      s1_hit_r       <= s1_hit_nxt;
      s1_p_r         <= s1_p_nxt;
      s1_d_r         <= s1_d_nxt;
      s1_base_r      <= base_sel;
    end
    if (out_free && s1_valid_r) begin
      out_kind_r      <= s1_kind_r;
      out_left_r      <= out_left_nxt;
      out_right_r     <= out_right_nxt;
      out_pid_reset_r <= s1_pid_reset_r;
      out_hit_r       <= s1_hit_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_kind    = out_kind_r;
  assign out_ch.left_target   = out_left_r;
  assign out_ch.right_target  = out_right_r;
  assign out_ch.pid_reset     = out_pid_reset_r;
  assign out_ch.stop_line_hit = out_hit_r;

  `LFPD_ASSERT_IMPLY(a_idle_targets_zero,
    out_valid_r && (out_kind_r != lfpd_pkg::KIND_SPEED),
    (out_left_r == '0) && (out_right_r == '0))
  `LFPD_ASSERT_IMPLY(a_speed_floor,
    out_valid_r && (out_kind_r == lfpd_pkg::KIND_SPEED),
    (out_left_r >= lfpd_pkg::MIN_SPEED) && (out_right_r >= lfpd_pkg::MIN_SPEED))
  `LFPD_ASSERT_IMPLY(a_hit_is_speed_tick,
    out_valid_r && out_hit_r,
    (out_kind_r == lfpd_pkg::KIND_SPEED) && !out_pid_reset_r)
  `LFPD_ASSERT_NEXT(a_hit_stops,
    in_fire && (in_ch.op == lfpd_pkg::OP_TICK) && (run_status_r != lfpd_pkg::RUN_STOPPED) &&
      stop_hit,
    (run_status_r == lfpd_pkg::RUN_STOPPED) && (brake_count_r == '0))

endmodule
`default_nettype wire
